[rtl/core/lcdnw_pkg.sv]
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, codes and helpers of the character display nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

  // Largest number of nibble writes that one item can cause.
  localparam int unsigned MaxNibbles = 10;
  localparam int unsigned CntW       = $clog2(MaxNibbles + 1);
  localparam int unsigned CursorW    = 7;

  // Configuration port geometry.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Item commands.
  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_RAW   = 2'd2,
    CMD_INIT  = 2'd3
  } lcdnw_cmd_e;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_CLEAR      = 3'd0,
    REG_MODE       = 3'd1,
    REG_DISPLAY_ON = 3'd2,
    REG_WAKE       = 3'd3,
    REG_FOUR_BIT   = 3'd4
  } lcdnw_reg_e;

  // Control characters with a special meaning.
  localparam logic [7:0] ChNul     = 8'd0;
  localparam logic [7:0] ChClear   = 8'd9;
  localparam logic [7:0] ChNewLine = 8'd10;
  localparam logic [7:0] ChCrLf    = 8'd12;
  localparam logic [7:0] ChCr      = 8'd13;

  // Display addresses and instructions.
  localparam logic [7:0] RowOneEnd   = 8'h0F;
  localparam logic [7:0] RowTwoStart = 8'h40;
  localparam logic [7:0] RowTwoEnd   = 8'h4F;
  localparam logic [6:0] HomeAddr    = 7'h00;
  localparam logic [6:0] RowTwoAddr  = 7'h40;

  // Register reset values.
  localparam logic [7:0] ClearReset     = 8'd1;
  localparam logic [7:0] ModeReset      = 8'd40;
  localparam logic [7:0] DisplayOnReset = 8'd12;
  localparam logic [3:0] WakeReset      = 4'd3;
  localparam logic [3:0] FourBitReset   = 4'd2;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] clear_code;
    logic [7:0] mode_code;
    logic [7:0] display_on_code;
    logic [3:0] wake_nibble;
    logic [3:0] four_bit_nibble;
  } lcdnw_cfg_t;

  // One decoded item: the nibbles to send, first in slot 0.
  typedef struct packed {
    logic                           rs;
    logic [MaxNibbles-1:0][3:0]     nib;
    logic [CntW-1:0]                count;
    logic [CursorW-1:0]             cursor;
  } lcdnw_run_t;

  // Cursor placement: wrap out-of-range addresses onto a visible row.
  function automatic logic [CursorW-1:0] lcdnw_place(input logic [7:0] row,
                                                     input logic [7:0] column);
    logic [7:0] addr;
    logic [CursorW-1:0] res;
    addr = {row[1:0], 6'b0} + column;
    if (addr > RowTwoEnd) begin
      res = HomeAddr;
    end else if (addr > RowOneEnd && addr < RowTwoStart) begin
      res = RowTwoAddr;
    end else begin
      res = addr[CursorW-1:0];
    end
    return res;
  endfunction

  // Set-address instruction for a cursor address.
  function automatic logic [7:0] lcdnw_addr_instr(input logic [CursorW-1:0] cursor);
    return {1'b1, cursor};
  endfunction

endpackage

`default_nettype wire

[rtl/core/char_lcd_nibble_writer_top.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top
// Character display writer for a 4-bit controller bus with cursor tracking.
// ----------------------------------------------------------------------------
// Each input transfer carries a command (tuser) and its operands (tdata); the
// block answers with one output transfer per nibble write, high nibble first,
// with tlast on the final nibble of the item. The output port delivers at most
// one nibble per cycle and holds while m_axis_tready is low. An item has two
// nibbles for a printed character, a new line, a carriage return, a placement
// or a raw instruction, four for clear and for carriage return plus line feed,
// ten for initialization. A NUL character is taken and produces no output.
// One decoded item waits in an input register while the previous one is
// shifted out, so items flow back to back. On an idle block the first nibble
// passes the input register, the active run register and the output register.
`default_nettype none

module char_lcd_nibble_writer_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lcdnw_pkg::AddrW-1:0]      paddr,
  input  wire logic [lcdnw_pkg::DataW-1:0]      pwdata,
  output logic      [lcdnw_pkg::DataW-1:0]      prdata,
  output logic                                  pready,
  // Input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: character[7:0], row[15:8], column[23:16], instruction_byte[31:24]
  input  wire logic [31:0]                      s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [1:0]                       s_axis_tuser,
  // Output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: nibble[3:0], cursor[10:4], zero[15:11]
  output logic [15:0]                           m_axis_tdata,
  // tuser: register_select
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  lcdnw_pkg::lcdnw_cfg_t          cfg;
  lcdnw_pkg::lcdnw_run_t          dec_run;
  lcdnw_pkg::lcdnw_run_t          pend_q;
  logic                           pend_valid_q;
  logic [lcdnw_pkg::CursorW-1:0]  cursor_q;
  logic                           run_take;
  logic                           in_xfer;
  logic                           out_rs;
  logic [3:0]                     out_nibble;
  logic                           out_last;
  logic [lcdnw_pkg::CursorW-1:0]  out_cursor;

  lcdnw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcdnw_decode u_decode (
    .command_i          (s_axis_tuser),
    .character_i        (s_axis_tdata[7:0]),
    .row_i              (s_axis_tdata[15:8]),
    .column_i           (s_axis_tdata[23:16]),
    .instruction_byte_i (s_axis_tdata[31:24]),
    .cursor_i           (cursor_q),
    .cfg_i              (cfg),
    .run_o              (dec_run)
  );

  // The input register frees up in the cycle the serializer takes it.
  assign s_axis_tready = !pend_valid_q || run_take;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Cursor tracking and input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q     <= lcdnw_pkg::HomeAddr;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        cursor_q     <= dec_run.cursor;
        pend_valid_q <= (dec_run.count != '0);
      end else if (run_take) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // Decoded run payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pend_q <= dec_run;
    end
  end

  lcdnw_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .run_i        (pend_q),
    .run_valid_i  (pend_valid_q),
    .run_take_o   (run_take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_rs_o     (out_rs),
    .out_nibble_o (out_nibble),
    .out_last_o   (out_last),
    .out_cursor_o (out_cursor)
  );

  assign m_axis_tdata = {5'b0, out_cursor, out_nibble};
  assign m_axis_tuser = out_rs;
  assign m_axis_tlast = out_last;

endmodule

`default_nettype wire

[rtl/core/lcdnw_cfg.sv]
// ----------------------------------------------------------------------------
// lcdnw_cfg
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lcdnw_pkg::AddrW-1:0]  paddr,
  input  wire logic [lcdnw_pkg::DataW-1:0]  pwdata,
  output logic      [lcdnw_pkg::DataW-1:0]  prdata,
  output logic                              pready,
  output lcdnw_pkg::lcdnw_cfg_t             cfg_o
);

  lcdnw_pkg::lcdnw_cfg_t cfg_q;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lcdnw_pkg::AddrW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg_o   = cfg_q;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_code      <= lcdnw_pkg::ClearReset;
      cfg_q.mode_code       <= lcdnw_pkg::ModeReset;
      cfg_q.display_on_code <= lcdnw_pkg::DisplayOnReset;
      cfg_q.wake_nibble     <= lcdnw_pkg::WakeReset;
      cfg_q.four_bit_nibble <= lcdnw_pkg::FourBitReset;
    end else if (wr_en) begin
      case (reg_idx)
        lcdnw_pkg::REG_CLEAR:      cfg_q.clear_code      <= pwdata[7:0];
        lcdnw_pkg::REG_MODE:       cfg_q.mode_code       <= pwdata[7:0];
        lcdnw_pkg::REG_DISPLAY_ON: cfg_q.display_on_code <= pwdata[7:0];
        lcdnw_pkg::REG_WAKE:       cfg_q.wake_nibble     <= pwdata[3:0];
        lcdnw_pkg::REG_FOUR_BIT:   cfg_q.four_bit_nibble <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    case (reg_idx)
      lcdnw_pkg::REG_CLEAR:      prdata = {24'b0, cfg_q.clear_code};
      lcdnw_pkg::REG_MODE:       prdata = {24'b0, cfg_q.mode_code};
      lcdnw_pkg::REG_DISPLAY_ON: prdata = {24'b0, cfg_q.display_on_code};
      lcdnw_pkg::REG_WAKE:       prdata = {28'b0, cfg_q.wake_nibble};
      lcdnw_pkg::REG_FOUR_BIT:   prdata = {28'b0, cfg_q.four_bit_nibble};
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/lcdnw_decode.sv]
// ----------------------------------------------------------------------------
// lcdnw_decode
// Turns one item into its list of nibble writes and the new cursor address.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_decode (
  input  wire logic [1:0]                      command_i,
  input  wire logic [7:0]                      character_i,
  input  wire logic [7:0]                      row_i,
  input  wire logic [7:0]                      column_i,
  input  wire logic [7:0]                      instruction_byte_i,
  input  wire logic [lcdnw_pkg::CursorW-1:0]   cursor_i,
  input  wire lcdnw_pkg::lcdnw_cfg_t           cfg_i,
  output lcdnw_pkg::lcdnw_run_t                run_o
);

  logic                              second_row;
  logic [lcdnw_pkg::CursorW-1:0]     other_row;
  logic [lcdnw_pkg::CursorW-1:0]     line_start;
  logic [lcdnw_pkg::CursorW-1:0]     crlf_start;
  logic [lcdnw_pkg::CursorW-1:0]     placed;
  logic [7:0]                        instr_a;
  logic [7:0]                        instr_b;

  // Row tests and the candidate cursor addresses of the control characters.
  always_comb begin
    second_row = (cursor_i[6:4] != 3'b0);
    other_row  = second_row ? {3'b0, cursor_i[3:0]} : (lcdnw_pkg::RowTwoAddr | {3'b0, cursor_i[3:0]});
    line_start = second_row ? lcdnw_pkg::RowTwoAddr : lcdnw_pkg::HomeAddr;
    crlf_start = (other_row[6:4] != 3'b0) ? lcdnw_pkg::RowTwoAddr : lcdnw_pkg::HomeAddr;
    placed     = lcdnw_pkg::lcdnw_place(row_i, column_i);
  end

  // Build the run: bytes go out high nibble first.
  always_comb begin
    run_o        = '0;
    run_o.cursor = cursor_i;
    instr_a      = '0;
    instr_b      = '0;
    case (command_i)
      lcdnw_pkg::CMD_CHAR: begin
        case (character_i)
          lcdnw_pkg::ChNul: begin
            run_o.count = '0;
          end
          lcdnw_pkg::ChClear: begin
            instr_a      = cfg_i.clear_code;
            instr_b      = lcdnw_pkg::lcdnw_addr_instr(lcdnw_pkg::HomeAddr);
            run_o.cursor = lcdnw_pkg::HomeAddr;
            run_o.count  = lcdnw_pkg::CntW'(4);
          end
          lcdnw_pkg::ChNewLine: begin
            instr_a      = lcdnw_pkg::lcdnw_addr_instr(other_row);
            run_o.cursor = other_row;
            run_o.count  = lcdnw_pkg::CntW'(2);
          end
          lcdnw_pkg::ChCrLf: begin
            instr_a      = lcdnw_pkg::lcdnw_addr_instr(other_row);
            instr_b      = lcdnw_pkg::lcdnw_addr_instr(crlf_start);
            run_o.cursor = crlf_start;
            run_o.count  = lcdnw_pkg::CntW'(4);
          end
          lcdnw_pkg::ChCr: begin
            instr_a      = lcdnw_pkg::lcdnw_addr_instr(line_start);
            run_o.cursor = line_start;
            run_o.count  = lcdnw_pkg::CntW'(2);
          end
          default: begin
            run_o.rs    = 1'b1;
            instr_a     = character_i;
            run_o.count = lcdnw_pkg::CntW'(2);
          end
        endcase
        run_o.nib[0] = instr_a[7:4];
        run_o.nib[1] = instr_a[3:0];
        run_o.nib[2] = instr_b[7:4];
        run_o.nib[3] = instr_b[3:0];
      end
      lcdnw_pkg::CMD_PLACE: begin
        instr_a      = lcdnw_pkg::lcdnw_addr_instr(placed);
        run_o.nib[0] = instr_a[7:4];
        run_o.nib[1] = instr_a[3:0];
        run_o.cursor = placed;
        run_o.count  = lcdnw_pkg::CntW'(2);
      end
      lcdnw_pkg::CMD_RAW: begin
        run_o.nib[0] = instruction_byte_i[7:4];
        run_o.nib[1] = instruction_byte_i[3:0];
        run_o.count  = lcdnw_pkg::CntW'(2);
      end
      default: begin
        // Power-up sequence: three wake nibbles, the bus width nibble, then
        // function set, display on and clear.
        run_o.nib[0] = cfg_i.wake_nibble;
        run_o.nib[1] = cfg_i.wake_nibble;
        run_o.nib[2] = cfg_i.wake_nibble;
        run_o.nib[3] = cfg_i.four_bit_nibble;
        run_o.nib[4] = cfg_i.mode_code[7:4];
        run_o.nib[5] = cfg_i.mode_code[3:0];
        run_o.nib[6] = cfg_i.display_on_code[7:4];
        run_o.nib[7] = cfg_i.display_on_code[3:0];
        run_o.nib[8] = cfg_i.clear_code[7:4];
        run_o.nib[9] = cfg_i.clear_code[3:0];
        run_o.cursor = lcdnw_pkg::HomeAddr;
        run_o.count  = lcdnw_pkg::CntW'(lcdnw_pkg::MaxNibbles);
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/lcdnw_serial.sv]
// ----------------------------------------------------------------------------
// lcdnw_serial
// Shifts a decoded run out one nibble per transfer through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_serial (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lcdnw_pkg::lcdnw_run_t             run_i,
  input  wire logic                              run_valid_i,
  output logic                                   run_take_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_rs_o,
  output logic [3:0]                             out_nibble_o,
  output logic                                   out_last_o,
  output logic [lcdnw_pkg::CursorW-1:0]          out_cursor_o
);

  logic [lcdnw_pkg::MaxNibbles-1:0][3:0] act_nib_q;
  logic [lcdnw_pkg::CntW-1:0]            act_cnt_q;
  logic                                  act_rs_q;
  logic [lcdnw_pkg::CursorW-1:0]         act_cur_q;
  logic                                  out_valid_q;
  logic                                  out_rs_q;
  logic [3:0]                            out_nib_q;
  logic                                  out_last_q;
  logic [lcdnw_pkg::CursorW-1:0]         out_cur_q;
  logic                                  out_adv;
  logic                                  act_busy;
  logic                                  act_empty_next;

  // The active run frees up once its last nibble moves to the output register.
  assign out_adv        = !out_valid_q || out_ready_i;
  assign act_busy       = (act_cnt_q != '0);
  assign act_empty_next = !act_busy ||
                          ((act_cnt_q == lcdnw_pkg::CntW'(1)) && out_adv);
  assign run_take_o     = run_valid_i && act_empty_next;

  // Control state: remaining nibble count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (run_take_o) begin
        act_cnt_q <= run_i.count;
      end else if (out_adv && act_busy) begin
        act_cnt_q <= act_cnt_q - lcdnw_pkg::CntW'(1);
      end
      if (out_adv) begin
        out_valid_q <= act_busy;
      end
    end
  end

  // Payload: load or shift the run, and fill the output register.
  always_ff @(posedge clk_i) begin
    if (run_take_o) begin
      act_nib_q <= run_i.nib;
      act_rs_q  <= run_i.rs;
      act_cur_q <= run_i.cursor;
    end else if (out_adv && act_busy) begin
      act_nib_q <= {4'b0, act_nib_q[lcdnw_pkg::MaxNibbles-1:1]};
    end
    if (out_adv && act_busy) begin
      out_rs_q   <= act_rs_q;
      out_nib_q  <= act_nib_q[0];
      out_last_q <= (act_cnt_q == lcdnw_pkg::CntW'(1));
      out_cur_q  <= act_cur_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_rs_o     = out_rs_q;
  assign out_nibble_o = out_nib_q;
  assign out_last_o   = out_last_q;
  assign out_cursor_o = out_cur_q;

endmodule

`default_nettype wire
